### rtl/calmg_pkg.sv
package calmg_pkg;

  // grid sizes and date limits
  localparam int GRID_CELLS = 42;
  localparam int SHORT_GRID = 35;
  localparam int YEAR_MAX   = 9999;
  localparam int MONTH_MAX  = 12;

  // reciprocal constants: x/100 exact for x < 43699, x/7 exact for x < 13110
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DIV7_MUL     = 9363;
  localparam int DIV7_SHIFT   = 16;

  // month codes
  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_MAR = 4'd3;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_MAY = 4'd5;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_JUL = 4'd7;
  localparam logic [3:0] MON_AUG = 4'd8;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_OCT = 4'd10;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  // front sequencer
  typedef enum logic [2:0] {
    FS_IDLE,
    FS_LEAP,
    FS_WDIV,
    FS_SUM,
    FS_MOD,
    FS_PUSH
  } front_state_t;

  // one grid job, handed from front to back
  typedef struct packed {
    logic [13:0] vy;
    logic [3:0]  vm;
    logic [13:0] py;
    logic [3:0]  pm;
    logic [13:0] ny;
    logic [3:0]  nm;
    logic [13:0] sy;
    logic [3:0]  sm;
    logic [4:0]  sd;
    logic [13:0] ty;
    logic [3:0]  tm;
    logic [4:0]  td;
    logic [2:0]  wd;
    logic [4:0]  len;
    logic [4:0]  plen;
    logic [5:0]  cells_last;
  } calmg_desc_t;

  // queue status toward the front
  typedef struct packed {
    logic full;
    logic empty;
  } calmg_q_stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    unique case (m)
      MON_FEB: d = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

  // Sakamoto month offsets
  function automatic logic [2:0] wday_off(input logic [3:0] m);
    logic [2:0] o;
    unique case (m)
      MON_JAN: o = 3'd0;
      MON_FEB: o = 3'd3;
      MON_MAR: o = 3'd2;
      MON_APR: o = 3'd5;
      MON_MAY: o = 3'd0;
      MON_JUN: o = 3'd3;
      MON_JUL: o = 3'd5;
      MON_AUG: o = 3'd1;
      MON_SEP: o = 3'd4;
      MON_OCT: o = 3'd6;
      MON_NOV: o = 3'd2;
      MON_DEC: o = 3'd4;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

endpackage

### rtl/calmg_front.sv
module calmg_front
  import calmg_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [63:0]   s_tdata,
  input  calmg_q_stat_t q_stat,
  output logic          push,
  output calmg_desc_t   push_desc
);

  front_state_t state, state_next;

  logic [13:0] vy, yy, sy, ty, sum;
  logic [3:0]  vm, sm, tm;
  logic [4:0]  sd, td;
  logic [6:0]  q100v, q100w;
  logic [10:0] q7;
  logic        leap;

  logic [13:0] in_vy, in_vy_c;
  logic [3:0]  in_vm, in_vm_c;
  logic [26:0] prod100;
  logic [27:0] prod7;
  logic [13:0] r100, rem, rem_fix;
  logic [2:0]  wd;
  logic [4:0]  len, plen;
  logic [5:0]  wl;

  assign in_vy = s_tdata[13:0];
  assign in_vm = s_tdata[17:14];

  // clamp the viewed date
  always_comb begin
    if (in_vy == 14'd0) begin
      in_vy_c = 14'd1;
    end else if (in_vy > 14'(YEAR_MAX)) begin
      in_vy_c = 14'(YEAR_MAX);
    end else begin
      in_vy_c = in_vy;
    end
    if (in_vm == 4'd0) begin
      in_vm_c = MON_JAN;
    end else if (in_vm > 4'(MONTH_MAX)) begin
      in_vm_c = MON_DEC;
    end else begin
      in_vm_c = in_vm;
    end
  end

  // shared divide-by-100 multiplier: viewed year first, weekday year next
  assign prod100 = 27'((state == FS_LEAP) ? vy : yy) * 27'(DIV100_MUL);
  assign r100    = vy - 14'(q100v) * 14'd100;

  // divide-by-7 for the weekday
  assign prod7 = 28'(sum) * 28'(DIV7_MUL);
  assign rem     = sum - 14'(q7) * 14'd7;
  assign rem_fix = (rem >= 14'd7) ? rem - 14'd7 : rem;
  assign wd      = rem_fix[2:0];

  assign len  = month_len(vm, leap);
  assign plen = month_len((vm == MON_JAN) ? MON_DEC : vm - 4'd1, leap);
  assign wl   = 6'(wd) + 6'(len);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      FS_IDLE: if (s_tvalid) state_next = FS_LEAP;
      FS_LEAP: state_next = FS_WDIV;
      FS_WDIV: state_next = FS_SUM;
      FS_SUM:  state_next = FS_MOD;
      FS_MOD:  state_next = FS_PUSH;
      FS_PUSH: if (!q_stat.full) state_next = FS_IDLE;
      default: state_next = FS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = (state == FS_IDLE);
    push     = (state == FS_PUSH) && !q_stat.full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      vy <= in_vy_c;
      vm <= in_vm_c;
      yy <= (in_vm_c < MON_MAR) ? in_vy_c - 14'd1 : in_vy_c;
      sy <= s_tdata[31:18];
      sm <= s_tdata[35:32];
      sd <= s_tdata[40:36];
      ty <= s_tdata[54:41];
      tm <= s_tdata[58:55];
      td <= s_tdata[63:59];
    end
    if (state == FS_LEAP) begin
      q100v <= prod100[DIV100_SHIFT +: 7];
    end
    if (state == FS_WDIV) begin
      q100w <= prod100[DIV100_SHIFT +: 7];
      leap  <= ((vy[1:0] == 2'd0) && (r100 != 14'd0)) ||
               ((r100 == 14'd0) && (q100v[1:0] == 2'd0));
    end
    if (state == FS_SUM) begin
      sum <= yy + {2'b00, yy[13:2]} - 14'(q100w) + 14'(q100w[6:2])
             + 14'(wday_off(vm)) + 14'd1;
    end
    if (state == FS_MOD) begin
      q7 <= prod7[DIV7_SHIFT +: 11];
    end
  end

  // job descriptor
  always_comb begin
    push_desc.vy         = vy;
    push_desc.vm         = vm;
    push_desc.py         = (vm == MON_JAN) ? vy - 14'd1 : vy;
    push_desc.pm         = (vm == MON_JAN) ? MON_DEC : vm - 4'd1;
    push_desc.ny         = (vm == MON_DEC) ? vy + 14'd1 : vy;
    push_desc.nm         = (vm == MON_DEC) ? MON_JAN : vm + 4'd1;
    push_desc.sy         = sy;
    push_desc.sm         = sm;
    push_desc.sd         = sd;
    push_desc.ty         = ty;
    push_desc.tm         = tm;
    push_desc.td         = td;
    push_desc.wd         = wd;
    push_desc.len        = len;
    push_desc.plen       = plen;
    push_desc.cells_last = (wl > 6'(SHORT_GRID)) ? 6'(GRID_CELLS - 1) : 6'(SHORT_GRID - 1);
  end

endmodule

### rtl/calmg_fifo.sv
module calmg_fifo
  import calmg_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  calmg_desc_t   push_desc,
  input  logic          pop,
  output calmg_desc_t   pop_desc,
  output calmg_q_stat_t q_stat
);

  calmg_desc_t slots [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);
  assign pop_desc     = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_desc;
  end

endmodule

### rtl/calmg_back.sv
module calmg_back
  import calmg_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  calmg_q_stat_t q_stat,
  input  calmg_desc_t   pop_desc,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [31:0]   m_tdata,
  output logic          m_tlast
);

  calmg_desc_t cur;
  logic        busy;
  logic [5:0]  idx;
  logic        advance;

  logic [6:0]  wl;
  logic        in_prev, in_cur;
  logic [13:0] cy;
  logic [3:0]  cm;
  logic [6:0]  cd7;
  logic [4:0]  cd;
  logic        gray, sel, tod;

  assign pop     = !busy && !q_stat.empty;
  assign advance = busy && (!m_tvalid || m_tready);

  // cell date for the current index
  always_comb begin
    wl      = 7'(cur.wd) + 7'(cur.len);
    in_prev = 7'(idx) < 7'(cur.wd);
    in_cur  = 7'(idx) < wl;
    if (in_prev) begin
      cy  = cur.py;
      cm  = cur.pm;
      cd7 = 7'(cur.plen) - 7'(cur.wd) + 7'd1 + 7'(idx);
    end else if (in_cur) begin
      cy  = cur.vy;
      cm  = cur.vm;
      cd7 = 7'(idx) - 7'(cur.wd) + 7'd1;
    end else begin
      cy  = cur.ny;
      cm  = cur.nm;
      cd7 = 7'(idx) - wl + 7'd1;
    end
    cd   = cd7[4:0];
    gray = (cm != cur.vm);
    sel  = (cy == cur.sy) && (cm == cur.sm) && (cd == cur.sd);
    tod  = !gray && (cy == cur.ty) && (cm == cur.tm) && (cd == cur.td);
  end

  // job control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (advance && (idx == cur.cells_last)) begin
        busy <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // job and output beat registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_desc;
      idx <= 6'd0;
    end else if (advance) begin
      idx <= idx + 6'd1;
    end
    if (advance) begin
      m_tdata <= {tod, gray, sel, cd, cm, cy, idx};
      m_tlast <= (idx == cur.cells_last);
    end
  end

endmodule

### rtl/calendar_month_grid_fill.sv
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata[63:0]: one query (viewed, selected, today dates)
// m_*      out  m_tvalid/m_tready  m_tdata[31:0] + m_tlast: one grid cell per beat
//
// The front sequencer takes each query through clamp, two divide-by-100 passes on
// one multiplier, weekday sum, divide-by-7 and hand-off; the back end then loads the
// job and sends 35 or 42 cells, one cell per cycle while m_tready does not stall it.
// A two-entry job queue lets the front take the next query while cells are still
// going out.
// rst is synchronous and active high; it empties the queue and drops any grid.
// m_tready low holds the current beat and stalls the back end; the front stalls once the queue is full.
module calendar_month_grid_fill
  import calmg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // view_year[13:0], view_month[17:14], sel_year[31:18], sel_month[35:32],
  // sel_day[40:36], today_year[54:41], today_month[58:55], today_day[63:59]
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cell_index[5:0], cell_year[19:6], cell_month[23:20], cell_day[28:24],
  // is_selected[29], is_gray[30], is_today[31]
  output logic [31:0] m_tdata,
  output logic        m_tlast
);

  calmg_q_stat_t q_stat;
  calmg_desc_t   push_desc, pop_desc;
  logic          push, pop;

  calmg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_desc (push_desc)
  );

  calmg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .q_stat    (q_stat)
  );

  calmg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop_desc (pop_desc),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### rtl/calmg_checker.sv
module calmg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  logic       out_beat;
  logic       in_grid;
  logic [5:0] prev_idx;

  assign out_beat = m_tvalid && m_tready;

  // track position within the current grid
  always_ff @(posedge clk) begin
    if (rst) begin
      in_grid  <= 1'b0;
      prev_idx <= 6'd0;
    end else if (out_beat) begin
      in_grid  <= !m_tlast;
      prev_idx <= m_tdata[5:0];
    end
  end

  // the front is busy after taking a query, so s_tready drops
  a_in_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on back-to-back cycles");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed under stall");

  // cells come out in order, starting at zero
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_beat |-> (m_tdata[5:0] == (in_grid ? prev_idx + 6'd1 : 6'd0)))
    else $error("cell index out of sequence");

  // a grid ends at 35 or 42 cells and never runs past 42
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_beat |-> (m_tlast ? ((m_tdata[5:0] == 6'd34) || (m_tdata[5:0] == 6'd41))
                          : (m_tdata[5:0] != 6'd41)))
    else $error("grid ends at wrong size");

  // today is never flagged on a gray cell, and cell days are never zero
  a_today: assert property (@(posedge clk) disable iff (rst)
    out_beat |-> !(m_tdata[31] && m_tdata[30]) && (m_tdata[28:24] != 5'd0))
    else $error("bad cell flags or day");

endmodule

bind calendar_month_grid_fill calmg_checker u_calmg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
